[src/hav_pkg.sv]
// ----------------------------------------------------------------------------
// hav_pkg
// Shared types and constants for the host address validator.
// ----------------------------------------------------------------------------
package hav_pkg;

	// Result codes
	typedef enum logic [1:0] {
		VERDICT_INVALID  = 2'd0,
		VERDICT_IPV4     = 2'd1,
		VERDICT_HOSTNAME = 2'd2
	} verdict_t;

	// Character codes
	localparam logic [7:0] CHAR_DOT    = 8'h2E;
	localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_NINE   = 8'h39;
	localparam logic [7:0] CHAR_UPR_A  = 8'h41;
	localparam logic [7:0] CHAR_UPR_Z  = 8'h5A;
	localparam logic [7:0] CHAR_LWR_A  = 8'h61;
	localparam logic [7:0] CHAR_LWR_Z  = 8'h7A;

	// IPv4 limits
	localparam logic [11:0] OCTET_MAX     = 12'd255;
	localparam logic [1:0]  OCTET_DIG_MAX = 2'd3;
	localparam logic [1:0]  DOT_MAX       = 2'd3;

	// Per-string scan state
	typedef struct packed {
		logic [1:0] dot_count;
		logic [7:0] octet_value;
		logic [1:0] octet_digits;
		logic       ipv4_failed;
		logic       seen_dot;
		logic       non_numeric_seen;
		logic [7:0] total_length;
		logic [6:0] label_length;
		logic       prev_was_hyphen;
		logic       hostname_failed;
	} hav_state_t;

	localparam hav_state_t STATE_CLEAR = '0;

endpackage

[src/host_address_validator_unit.sv]
// ----------------------------------------------------------------------------
// host_address_validator_unit
// Streams a host string one character per transfer and classifies it as
// IPv4 literal, hostname or invalid when the tlast transfer arrives.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle unless a held verdict is stalled by
//   the sink; the input register feeds a combinational state update, and
//   the output register takes the verdict, which then shows on m_axis.
// Reset: arst_n clears all scan state and both valid flags; data registers
//   are not reset.
// ----------------------------------------------------------------------------
module host_address_validator_unit #(
	parameter int MAX_NAME_LEN  = 253,	// 1..255, longest accepted hostname
	parameter int MAX_LABEL_LEN = 63	// 1..127, longest accepted label
) (
	input  logic       clk,
	input  logic       arst_n,

	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,	// [7:0] char_code
	input  logic       s_axis_tuser,	// [0] no_char
	input  logic       s_axis_tlast,	// end of string

	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata	// [1:0] verdict, [7:2] zero
);

	// input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       no_char_s1;
	logic       last_s1;

	// scan state and output register
	hav_pkg::hav_state_t state_q;
	hav_pkg::hav_state_t state_nxt;
	hav_pkg::verdict_t   verdict_nxt;
	hav_pkg::verdict_t   verdict_q;
	logic                out_valid_q;

	logic advance;	// stage 1 item is consumed this cycle

	// The output register may be refilled in the cycle it is drained, so the
	// input side only stalls when a verdict is held and the sink is stalled.
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1    <= s_axis_tdata;
			no_char_s1 <= s_axis_tuser;
			last_s1    <= s_axis_tlast;
		end
	end

	hav_step #(
		.MAX_NAME_LEN  (MAX_NAME_LEN),
		.MAX_LABEL_LEN (MAX_LABEL_LEN)
	) u_step (
		.cur       (state_q),
		.char_code (char_s1),
		.no_char   (no_char_s1),
		.last      (last_s1),
		.nxt       (state_nxt),
		.verdict   (verdict_nxt)
	);

	// scan state; cleared by the step logic after each verdict
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hav_pkg::STATE_CLEAR;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// verdict register: only strings ending in this cycle produce a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			verdict_q <= verdict_nxt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, verdict_q};

endmodule

[src/hav_step.sv]
// ----------------------------------------------------------------------------
// hav_step
// One-character update of the scan state plus end-of-string verdict.
// ----------------------------------------------------------------------------
module hav_step #(
	parameter int MAX_NAME_LEN  = 253,
	parameter int MAX_LABEL_LEN = 63
) (
	input  hav_pkg::hav_state_t cur,
	input  logic [7:0]          char_code,
	input  logic                no_char,
	input  logic                last,
	output hav_pkg::hav_state_t nxt,
	output hav_pkg::verdict_t   verdict
);

	logic               is_digit;
	logic               is_alnum;
	logic               is_dot;
	logic               is_hyphen;
	logic [11:0]        octet_sum;
	hav_pkg::hav_state_t upd;

	always_comb begin
		is_digit  = char_code inside {[hav_pkg::CHAR_ZERO:hav_pkg::CHAR_NINE]};
		is_alnum  = is_digit
			|| (char_code inside {[hav_pkg::CHAR_UPR_A:hav_pkg::CHAR_UPR_Z]})
			|| (char_code inside {[hav_pkg::CHAR_LWR_A:hav_pkg::CHAR_LWR_Z]});
		is_dot    = (char_code == hav_pkg::CHAR_DOT);
		is_hyphen = (char_code == hav_pkg::CHAR_HYPHEN);
		octet_sum = 12'(cur.octet_value) * 12'd10 + 12'(char_code[3:0]);

		upd = cur;
		if (!no_char) begin
			// dotted quad
			if (!cur.ipv4_failed) begin
				if (is_digit) begin
					if (octet_sum > hav_pkg::OCTET_MAX
							|| cur.octet_digits >= hav_pkg::OCTET_DIG_MAX) begin
						upd.ipv4_failed = 1'b1;
					end else begin
						upd.octet_value  = octet_sum[7:0];
						upd.octet_digits = cur.octet_digits + 2'd1;
					end
				end else if (is_dot) begin
					if (cur.octet_digits == 2'd0 || cur.dot_count >= hav_pkg::DOT_MAX) begin
						upd.ipv4_failed = 1'b1;
					end else begin
						upd.dot_count    = cur.dot_count + 2'd1;
						upd.octet_value  = '0;
						upd.octet_digits = '0;
					end
				end else begin
					upd.ipv4_failed = 1'b1;
				end
			end

			// digits-and-dots detector
			if (is_dot) begin
				upd.seen_dot = 1'b1;
			end else if (!is_digit) begin
				upd.non_numeric_seen = 1'b1;
			end

			// hostname: length saturates, overflow fails
			if (cur.total_length >= 8'(MAX_NAME_LEN)) begin
				upd.hostname_failed = 1'b1;
			end else begin
				upd.total_length = cur.total_length + 8'd1;
			end
			if (!upd.hostname_failed) begin
				if (is_dot) begin
					if (cur.label_length == 7'd0 || cur.prev_was_hyphen) begin
						upd.hostname_failed = 1'b1;
					end else begin
						upd.label_length    = '0;
						upd.prev_was_hyphen = 1'b0;
					end
				end else if (!is_alnum && !is_hyphen) begin
					upd.hostname_failed = 1'b1;
				end else if (cur.label_length == 7'd0 && is_hyphen) begin
					upd.hostname_failed = 1'b1;
				end else if (cur.label_length >= 7'(MAX_LABEL_LEN)) begin
					upd.hostname_failed = 1'b1;
				end else begin
					upd.label_length    = cur.label_length + 7'd1;
					upd.prev_was_hyphen = is_hyphen;
				end
			end
		end

		// verdict on the updated state
		if (!upd.ipv4_failed && upd.dot_count == hav_pkg::DOT_MAX
				&& upd.octet_digits != 2'd0) begin
			verdict = hav_pkg::VERDICT_IPV4;
		end else if (upd.seen_dot && !upd.non_numeric_seen) begin
			verdict = hav_pkg::VERDICT_INVALID;
		end else if (!upd.hostname_failed && upd.total_length != 8'd0
				&& upd.label_length != 7'd0 && !upd.prev_was_hyphen) begin
			verdict = hav_pkg::VERDICT_HOSTNAME;
		end else begin
			verdict = hav_pkg::VERDICT_INVALID;
		end

		nxt = last ? hav_pkg::STATE_CLEAR : upd;
	end

endmodule

[test/host_address_validator_unit_tb.sv]
// ----------------------------------------------------------------------------
// host_address_validator_unit_tb
// Streams host strings into the validator one character per transfer and
// checks every verdict against a cycle-free scan model kept in the bench.
// Directed strings cover the IPv4, digits-and-dots and hostname rules.
// Length tests cover the label and name limits. A long random run mixes
// dotted quads, hostnames and noise, with random gaps on both streams.
// ----------------------------------------------------------------------------
module host_address_validator_unit_tb;

	localparam int NAME_LIMIT   = 253;
	localparam int LABEL_LIMIT  = 63;
	localparam int LATENCY      = 2;
	localparam int RANDOM_ITEMS = 950;

	typedef logic [7:0] char_q_t[$];

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;

	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'd0;	// [7:0] char_code
	logic       s_axis_tuser = 1'b0;	// [0] no_char
	logic       s_axis_tlast = 1'b0;	// end of string

	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;	// [1:0] verdict, [7:2] zero

	// Bench-side copy of the scan state, and verdicts still owed by the DUT
	hav_pkg::hav_state_t scan_st = hav_pkg::STATE_CLEAR;
	hav_pkg::verdict_t   verdict_q[$];

	int    idle_max    = 0;	// longest gap either side may draw
	int    stall_left  = 0;
	int    stall_draw;
	int    error_count = 0;
	int    items_sent  = 0;
	hav_pkg::verdict_t want;
	string alnum_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";

	host_address_validator_unit #(
		.MAX_NAME_LEN (NAME_LIMIT),
		.MAX_LABEL_LEN(LABEL_LIMIT)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Scan model: one character through the three checks
	// ------------------------------------------------------------------------
	function automatic void absorb_char(input logic [7:0] c);
		logic is_dig;
		logic is_hyph;
		logic is_alnum;
		int   v;
		is_dig   = (c >= hav_pkg::CHAR_ZERO) && (c <= hav_pkg::CHAR_NINE);
		is_hyph  = (c == hav_pkg::CHAR_HYPHEN);
		is_alnum = is_dig || ((c >= hav_pkg::CHAR_UPR_A) && (c <= hav_pkg::CHAR_UPR_Z)) ||
			((c >= hav_pkg::CHAR_LWR_A) && (c <= hav_pkg::CHAR_LWR_Z));

		// dotted quad; counters freeze once it has failed
		if (!scan_st.ipv4_failed) begin
			if (is_dig) begin
				v = int'(scan_st.octet_value) * 10 + int'(c) - int'(hav_pkg::CHAR_ZERO);
				if (v > 255 || scan_st.octet_digits >= 2'd3) begin
					scan_st.ipv4_failed = 1'b1;
				end else begin
					scan_st.octet_value  = 8'(v);
					scan_st.octet_digits = scan_st.octet_digits + 2'd1;
				end
			end else if (c == hav_pkg::CHAR_DOT) begin
				if (scan_st.octet_digits == 2'd0 || scan_st.dot_count >= 2'd3) begin
					scan_st.ipv4_failed = 1'b1;
				end else begin
					scan_st.dot_count    = scan_st.dot_count + 2'd1;
					scan_st.octet_value  = 8'd0;
					scan_st.octet_digits = 2'd0;
				end
			end else begin
				scan_st.ipv4_failed = 1'b1;
			end
		end

		// digits-and-dots detector
		if (c == hav_pkg::CHAR_DOT)
			scan_st.seen_dot = 1'b1;
		else if (!is_dig)
			scan_st.non_numeric_seen = 1'b1;

		// hostname; total length saturates at the limit
		if (int'(scan_st.total_length) >= NAME_LIMIT)
			scan_st.hostname_failed = 1'b1;
		else
			scan_st.total_length = scan_st.total_length + 8'd1;
		if (!scan_st.hostname_failed) begin
			if (c == hav_pkg::CHAR_DOT) begin
				if (scan_st.label_length == 7'd0 || scan_st.prev_was_hyphen) begin
					scan_st.hostname_failed = 1'b1;
				end else begin
					scan_st.label_length    = 7'd0;
					scan_st.prev_was_hyphen = 1'b0;
				end
			end else if (!is_alnum && !is_hyph) begin
				scan_st.hostname_failed = 1'b1;
			end else if (scan_st.label_length == 7'd0 && is_hyph) begin
				scan_st.hostname_failed = 1'b1;
			end else if (int'(scan_st.label_length) >= LABEL_LIMIT) begin
				scan_st.hostname_failed = 1'b1;
			end else begin
				scan_st.label_length    = scan_st.label_length + 7'd1;
				scan_st.prev_was_hyphen = is_hyph;
			end
		end
	endfunction

	// Verdict priority: IPv4, then numeric-looking reject, then hostname
	function automatic hav_pkg::verdict_t judge_string();
		if (!scan_st.ipv4_failed && scan_st.dot_count == 2'd3 && scan_st.octet_digits != 2'd0)
			return hav_pkg::VERDICT_IPV4;
		if (scan_st.seen_dot && !scan_st.non_numeric_seen)
			return hav_pkg::VERDICT_INVALID;
		if (!scan_st.hostname_failed && scan_st.total_length != 8'd0 &&
			scan_st.label_length != 7'd0 && !scan_st.prev_was_hyphen)
			return hav_pkg::VERDICT_HOSTNAME;
		return hav_pkg::VERDICT_INVALID;
	endfunction

	// ------------------------------------------------------------------------
	// Input side: one transfer, with a random gap in front of it.
	// tvalid is only lowered when a gap is drawn, so back-to-back transfers
	// never see a low and a high assignment in the same step.
	// ------------------------------------------------------------------------
	task automatic send_item(input logic [7:0] code, input logic nc, input logic lst);
		int gap;
		gap = (idle_max > 0) ? $urandom_range(idle_max, 0) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= code;
		s_axis_tuser  <= nc;
		s_axis_tlast  <= lst;
		do @(posedge clk); while (!s_axis_tready);
		if (!nc)
			absorb_char(code);
		if (lst) begin
			verdict_q.push_back(judge_string());
			scan_st = hav_pkg::STATE_CLEAR;
		end
		items_sent++;
	endtask

	// One string; ends on its last character or on a separate end-only item.
	// Filler items get random char_code so that field toggles under no_char.
	task automatic send_bytes(input char_q_t txt, input bit end_marker, input bit fillers);
		for (int i = 0; i < txt.size(); i++) begin
			if (fillers && $urandom_range(7, 0) == 0)
				send_item(8'($urandom_range(255, 0)), 1'b1, 1'b0);
			send_item(txt[i], 1'b0, !end_marker && (i == txt.size() - 1));
		end
		if (end_marker || txt.size() == 0)
			send_item(8'($urandom_range(255, 0)), 1'b1, 1'b1);
	endtask

	// Stop sending and wait for every owed verdict, plus pipeline slack
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// Labels of the given lengths joined by dots, all one fill character
	task automatic send_labels(input int lens[$], input logic [7:0] fill, input bit end_marker);
		char_q_t txt;
		for (int k = 0; k < lens.size(); k++) begin
			if (k > 0)
				txt.push_back(hav_pkg::CHAR_DOT);
			repeat (lens[k]) txt.push_back(fill);
		end
		send_bytes(txt, end_marker, 1'b0);
	endtask

	// ------------------------------------------------------------------------
	// Output side: stall draw per verdict, compare against the oldest owed one
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left    <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (verdict_q.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("verdict transfer with none owed: tdata=0x%02h", m_axis_tdata);
				end else begin
					want = verdict_q.pop_front();
					if (m_axis_tdata !== {6'd0, want}) begin
						error_count++;
						if (error_count <= 10)
							$display("verdict mismatch: expected %s (0x%02h), got 0x%02h",
								want.name(), {6'd0, want}, m_axis_tdata);
					end
				end
				stall_draw = (idle_max > 0) ? $urandom_range(idle_max, 0) : 0;
				m_axis_tready <= (stall_draw == 0);
				stall_left    <= stall_draw;
			end else if (stall_left > 1) begin
				stall_left <= stall_left - 1;
			end else begin
				stall_left    <= 0;
				m_axis_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Hand-picked strings, no gaps on either side
	task automatic test_directed();
		string   cases[$];
		char_q_t txt;
		idle_max = 0;
		cases = '{"0.0.0.0", "255.255.255.255", "256.1.1.1", "1.2.3", "1.2.3.4.5",
			"1.2.3.", ".1.2.3", "1234.1.1.1", "01.002.3.4", "1..2.3", "123",
			"1.2.3.4a", "example.com", "A9.Z0", "a", "-abc", "abc-", "a-b.c-d",
			"a..b", "a.", "host_name"};
		foreach (cases[i]) begin
			txt.delete();
			for (int j = 0; j < cases[i].len(); j++)
				txt.push_back(cases[i][j]);
			send_bytes(txt, 1'b0, 1'b0);
		end
		// empty string: end-only item with nothing before it
		txt.delete();
		send_bytes(txt, 1'b1, 1'b0);
		// bytes outside the alphabet, high bit set, NUL
		send_bytes('{8'hFF}, 1'b0, 1'b0);
		send_bytes('{hav_pkg::CHAR_LWR_A, 8'h00}, 1'b0, 1'b0);
		send_bytes('{hav_pkg::CHAR_LWR_A, 8'hE1, hav_pkg::CHAR_LWR_Z}, 1'b0, 1'b0);
		// filler items in the middle, then a separate end item
		send_item(8'hA5, 1'b1, 1'b0);
		send_item(hav_pkg::CHAR_LWR_A, 1'b0, 1'b0);
		send_item(8'h5A, 1'b1, 1'b0);
		send_item(hav_pkg::CHAR_DOT, 1'b0, 1'b0);
		send_item(hav_pkg::CHAR_LWR_Z, 1'b0, 1'b0);
		send_item(8'hFF, 1'b1, 1'b1);
		drain_results();
	endtask

	// Label and name length limits, including counter saturation
	task automatic test_length_limits();
		idle_max = 3;
		send_labels('{LABEL_LIMIT}, hav_pkg::CHAR_LWR_A, 1'b0);	// longest label
		send_labels('{LABEL_LIMIT + 1}, hav_pkg::CHAR_LWR_A, 1'b0);	// one over
		// 253 characters, longest name
		send_labels('{LABEL_LIMIT, LABEL_LIMIT, LABEL_LIMIT, 61}, hav_pkg::CHAR_UPR_Z, 1'b0);
		// 254 characters, saturates, separate end item
		send_labels('{LABEL_LIMIT, LABEL_LIMIT, LABEL_LIMIT, 62}, hav_pkg::CHAR_UPR_Z, 1'b1);
		drain_results();
	endtask

	// Mostly well-formed quads and hostnames with random content, plus noise
	task automatic test_random_strings();
		char_q_t txt;
		char_q_t dq;
		int n;
		int kind;
		int cnt;
		int len;
		int v;
		int r;
		bit pad;
		int start;
		n = 0;
		start = items_sent;
		while (items_sent < start + RANDOM_ITEMS) begin
			// switch between idle-free stretches and heavy gaps
			if (n % 16 == 0)
				idle_max = ($urandom_range(2, 0) == 0) ? 0 : 19;
			// once, hold off until everything owed has come back
			if (n == 40)
				drain_results();
			txt.delete();
			kind = $urandom_range(9, 0);
			case (kind)
				0, 1, 2, 9: begin
					cnt = ($urandom_range(3, 0) != 0) ? 4 : $urandom_range(5, 3);
					for (int k = 0; k < cnt; k++) begin
						if (k > 0)
							txt.push_back(hav_pkg::CHAR_DOT);
						r = $urandom_range(9, 0);
						v = (r < 7) ? $urandom_range(255, 0) :
							(r < 9) ? $urandom_range(999, 256) : $urandom_range(9999, 1000);
						pad = ($urandom_range(5, 0) == 0);
						dq.delete();
						do begin
							dq.push_front(8'(int'(hav_pkg::CHAR_ZERO) + v % 10));
							v = v / 10;
						end while (v > 0);
						if (pad)
							dq.push_front(hav_pkg::CHAR_ZERO);
						txt = {txt, dq};
					end
					if (kind == 9)	// quad with one character broken
						txt[$urandom_range(txt.size() - 1, 0)] = 8'($urandom_range(255, 0));
				end
				3, 4, 5: begin
					cnt = $urandom_range(4, 1);
					for (int k = 0; k < cnt; k++) begin
						if (k > 0)
							txt.push_back(hav_pkg::CHAR_DOT);
						len = ($urandom_range(15, 0) == 0) ? $urandom_range(66, 60) :
							$urandom_range(12, 1);
						for (int j = 0; j < len; j++) begin
							if (j > 0 && j < len - 1 && $urandom_range(4, 0) == 0)
								txt.push_back(hav_pkg::CHAR_HYPHEN);
							else
								txt.push_back(alnum_set[$urandom_range(61, 0)]);
						end
					end
				end
				6: begin
					len = $urandom_range(12, 1);
					repeat (len) begin
						if ($urandom_range(3, 0) == 0)
							txt.push_back(hav_pkg::CHAR_DOT);
						else
							txt.push_back(8'(int'(hav_pkg::CHAR_ZERO) + $urandom_range(9, 0)));
					end
				end
				7: begin
					len = $urandom_range(8, 0);
					repeat (len) txt.push_back(8'($urandom_range(255, 0)));
				end
				default: begin
					len = $urandom_range(16, 1);
					repeat (len) begin
						r = $urandom_range(9, 0);
						if (r < 6)
							txt.push_back(alnum_set[$urandom_range(61, 0)]);
						else if (r == 6)
							txt.push_back(hav_pkg::CHAR_HYPHEN);
						else if (r == 7)
							txt.push_back(hav_pkg::CHAR_DOT);
						else if (r == 8)
							txt.push_back(8'($urandom_range(255, 128)));
						else
							txt.push_back(8'($urandom_range(255, 0)));
					end
				end
			endcase
			// occasional corruption of otherwise clean strings
			if (txt.size() > 0 && $urandom_range(7, 0) == 0)
				txt[$urandom_range(txt.size() - 1, 0)] = 8'($urandom_range(255, 0));
			send_bytes(txt, ($urandom_range(5, 0) == 0), 1'b1);
			n++;
		end
		drain_results();
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_length_limits();
		test_random_strings();
		if (error_count == 0 && verdict_q.size() == 0) begin
			$display("host_address_validator_unit_tb: PASS");
		end else begin
			$display("host_address_validator_unit_tb: FAIL");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest legal run
	initial begin
		#5000000;
		$display("host_address_validator_unit_tb: FAIL");
		$finish;
	end

endmodule
